// ===== design/sha256_pkg.sv =====
// SHA-256 package: constants, types and round functions.
// Used by the front, fifo, back and top modules of the sha256_message_hasher_core block.
package sha256_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned Rounds     = 64;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_FINAL
  } kind_e;

  // Word handed from the front to the back.
  typedef struct packed {
    word_t      data;
    logic [2:0] nbytes;
    kind_e      kind;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } back_state_e;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== design/sha256_front.sv =====
// Input side: accepts message words, clamps the byte count, tags the kind.
// Depends on sha256_pkg.
module sha256_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [31:0]        s_tdata_i,
  input  logic [2:0]         s_tuser_i,
  input  logic               s_tlast_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output sha256_pkg::item_t  q_item_o
);
  import sha256_pkg::*;

  item_t item_q, item_d;
  logic  valid_q, valid_d;

  assign s_tready_o = !valid_q || q_ready_i;
  assign q_valid_o  = valid_q;
  assign q_item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (q_ready_i) valid_d = 1'b0;
    if (s_tvalid_i && s_tready_o) begin
      valid_d       = 1'b1;
      item_d.data   = s_tdata_i;
      item_d.kind   = s_tlast_i ? KIND_FINAL : KIND_DATA;
      // short counts only mean something on the final word
      if (!s_tlast_i || s_tuser_i > 3'd4) item_d.nbytes = 3'd4;
      else item_d.nbytes = s_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) item_q <= item_d;
endmodule

// ===== design/sha256_fifo.sv =====
// Short queue between front and back.
// Depends on sha256_pkg.
module sha256_fifo #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sha256_pkg::item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha256_pkg::item_t out_item_o
);
  import sha256_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule

// ===== design/sha256_back.sv =====
// Compression engine: block buffer, padding, 64 rounds one per cycle, digest out.
// Depends on sha256_pkg.
module sha256_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  sha256_pkg::item_t q_item_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [34:0]       m_tdata_o,
  output logic              m_tlast_o
);
  import sha256_pkg::*;

  back_state_e state_q, state_d;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];  // message schedule window, w_q[0] oldest
  logic [3:0]  pos_q;
  logic [5:0]  rnd_q;
  logic [63:0] bytes_q;
  logic        fin_q;     // final word taken: padding follows
  logic        lenp_q;    // padding needs a length block after this one
  logic        mark_q;    // full final word: 0x80 marker still owed as a padding word
  logic [2:0]  oidx_q;
  logic        ovalid_q;

  logic        take, write_word, emit_go;
  word_t       pad_word, t1, t2, wnew;
  logic [63:0] bits;

  assign bits = {bytes_q[60:0], 3'b000};
  assign take = (state_q == ST_IDLE) && q_valid_i;
  assign q_ready_o = state_q == ST_IDLE;

  // padding word for slot pos_q once the final word was consumed
  always_comb begin
    if (mark_q) pad_word = 32'h8000_0000;
    else if (pos_q == 4'd14 && !lenp_q) pad_word = bits[63:32];
    else if (pos_q == 4'd15 && !lenp_q) pad_word = bits[31:0];
    else pad_word = '0;
  end

  logic [31:0] keep;
  always_comb begin
    case (q_item_i.nbytes)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hff00_0000;
      3'd2:    keep = 32'hffff_0000;
      3'd3:    keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
  end

  logic [31:0] marker;
  always_comb begin
    case (q_item_i.nbytes)
      3'd0:    marker = 32'h8000_0000;
      3'd1:    marker = 32'h0080_0000;
      3'd2:    marker = 32'h0000_8000;
      3'd3:    marker = 32'h0000_0080;
      default: marker = 32'h0000_0000;
    endcase
  end

  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_q[0];
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign wnew = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
  assign emit_go = ovalid_q && m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (take) state_d = ST_LOAD;
      ST_LOAD:  state_d = (pos_q == 4'd15) ? ST_ROUND : (fin_q ? ST_PAD : ST_IDLE);
      ST_PAD:   if (pos_q == 4'd15) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = (fin_q && !lenp_q) ? ST_EMIT : (fin_q ? ST_PAD : ST_IDLE);
      ST_EMIT:  if (emit_go && oidx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    write_word = (state_q == ST_LOAD) || (state_q == ST_PAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      h_q      <= InitH;
      pos_q    <= '0;
      rnd_q    <= '0;
      bytes_q  <= '0;
      fin_q    <= 1'b0;
      lenp_q   <= 1'b0;
      mark_q   <= 1'b0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        bytes_q <= bytes_q + 64'(q_item_i.nbytes);
        if (q_item_i.kind == KIND_FINAL) fin_q <= 1'b1;
        mark_q <= (q_item_i.kind == KIND_FINAL) && (q_item_i.nbytes == 3'd4);
      end
      if (state_q == ST_PAD) mark_q <= 1'b0;
      if (write_word) begin
        pos_q <= pos_q + 1'b1;
        // a length that no longer fits goes in the next block
        if (state_q == ST_LOAD && fin_q && (pos_q > 4'd13 || (mark_q && pos_q == 4'd13)))
          lenp_q <= 1'b1;
      end
      if (state_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        lenp_q <= 1'b0;
        if (fin_q && !lenp_q) begin
          ovalid_q <= 1'b1;
          oidx_q   <= '0;
        end
      end
      if (emit_go) begin
        oidx_q <= oidx_q + 1'b1;
        if (oidx_q == 3'd7) begin
          ovalid_q <= 1'b0;
          h_q      <= InitH;
          bytes_q  <= '0;
          fin_q    <= 1'b0;
        end
      end
    end
  end

  // payload: block words shift in, the window then acts as the schedule
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      if (q_item_i.kind == KIND_FINAL && q_item_i.nbytes != 3'd4)
        w_q[15] <= (q_item_i.data & keep) | marker;
      else w_q[15] <= q_item_i.data;
    end
    if (state_q == ST_PAD) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= pad_word;
    end
    if (write_word && pos_q == 4'd15) v_q <= h_q;
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = {oidx_q, h_q[oidx_q]};
  assign m_tlast_o  = oidx_q == 3'd7;
endmodule

// ===== design/sha256_message_hasher_core.sv =====
// SHA-256 hasher top. The back end takes a data word in ST_IDLE and writes it in ST_LOAD;
// every 16th word adds a compression (64 rounds one per cycle, then the hash update), and
// no word is taken meanwhile. The final word adds padding to fill the block, one or two
// compressions, then 8 digest words, one per cycle while the sink is ready. Reset (rst_ni
// low, async) loads the initial hash values and clears counters; the block is then ready.
module sha256_message_hasher_core #(
  parameter int unsigned QDepth = sha256_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // message_word
  input  logic [2:0]  s_axis_tuser,   // valid_bytes
  input  logic        s_axis_tlast,   // final_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], digest_index[34:32], pad
  output logic        m_axis_tlast    // digest_done
);
  import sha256_pkg::*;

  item_t f_item, q_item;
  logic  f_valid, f_ready, q_valid, q_ready;
  logic [34:0] data;

  sha256_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser), .s_tlast_i(s_axis_tlast),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_item_o(f_item)
  );

  sha256_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_item_i(f_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  sha256_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_o(data), .m_tlast_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, data};
endmodule

// ===== design/sha256_checker.sv =====
// Port-level checks for sha256_message_hasher_core, bound to the top level.
// Depends on the top-level port list only.
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast not on index 7");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest index did not advance");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled word changed");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
    else $error("pad bits set");
endmodule

bind sha256_message_hasher_core sha256_checker u_checker (.*);
